### hdl/tlpt_pkg.sv
// Shared types and constants for the two-level page table block.
`default_nettype none
package tlpt_pkg;

  typedef enum logic [1:0] {
    KIND_MAP_LARGE = 2'd0,
    KIND_MAP_SMALL = 2'd1,
    KIND_TRANSLATE = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_TABLE = 2'd1;
  localparam logic [1:0] STATUS_OVER_BIG = 2'd2;

  localparam logic [31:0] LARGE_MASK = 32'hFFC00000;
  localparam logic [31:0] FRAME_MASK = 32'hFFFFF000;
  localparam logic [31:0] LARGE_OFF  = 32'h003FFFFF;
  localparam logic [31:0] SMALL_OFF  = 32'h00000FFF;
  localparam logic [31:0] SIZE_BIT   = 32'h00000080;
  localparam logic [31:0] LINK_FLAGS = 32'h00000003;
  localparam int          DIR_SIZE   = 1024;
  localparam int          IDX_W      = 10;
  localparam int          CNT_W      = 11;

  // Item as queued between front and back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] lin_addr;
    logic [31:0] phys_addr;
    logic [11:0] flags;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIR,
    ST_TBL,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### hdl/tlpt_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### hdl/tlpt_front.sv
// Front: accepts items into a two-entry queue.
`default_nettype none
module tlpt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tlpt_pkg::item_t in_item,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output tlpt_pkg::item_t      q_item
);
  tlpt_pkg::item_t slot_r [2];
  logic            wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  // Pointer and count updates
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= in_item;
    end
  end
endmodule
`default_nettype wire

### hdl/tlpt_back.sv
// Back: clears memories after reset, then walks and updates the tables.
`default_nettype none
module tlpt_back #(
  parameter int TABLE_COUNT = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [19:0]     pool_frame,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire tlpt_pkg::item_t q_item,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output logic [31:0]          res_phys,
  output logic                 res_mapped,
  output logic [1:0]           res_status
);
  localparam int TW   = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int PW   = $clog2(TABLE_COUNT * tlpt_pkg::DIR_SIZE);
  localparam int CLRW = (PW > tlpt_pkg::IDX_W) ? PW : tlpt_pkg::IDX_W;

  tlpt_pkg::state_t state_r, state_nxt;
  logic [CLRW:0]    clr_r, clr_nxt;
  tlpt_pkg::item_t  it_r;
  logic [TW-1:0]    tsel_r, tsel_nxt;
  logic [31:0]      phys_r, phys_nxt;
  logic             map_r, map_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [tlpt_pkg::CNT_W-1:0] cnt_r [TABLE_COUNT];

  // Memory ports
  logic                     dir_we, pool_we;
  logic [tlpt_pkg::IDX_W-1:0] dir_addr;
  logic [PW-1:0]            pool_addr;
  logic [31:0]              dir_wd, dir_rd, pool_wd, pool_rd;

  tlpt_ram #(.WIDTH(32), .DEPTH(tlpt_pkg::DIR_SIZE)) u_dir (
    .clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wd), .rdata(dir_rd));
  tlpt_ram #(.WIDTH(32), .DEPTH(TABLE_COUNT * tlpt_pkg::DIR_SIZE)) u_pool (
    .clk(clk), .we(pool_we), .addr(pool_addr), .wdata(pool_wd), .rdata(pool_rd));

  // Free-table search and pool index of the directory entry
  logic          free_found;
  logic [TW-1:0] free_idx;
  logic [19:0]   pidx;
  logic          in_pool;
  logic [TW-1:0] pool_t;
  logic [9:0]    di, ti;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_COUNT - 1; i >= 0; i--) begin
      if (cnt_r[i] == '0) begin
        free_found = 1'b1;
        free_idx   = TW'(i);
      end
    end
    pidx    = dir_rd[31:12] - pool_frame;
    in_pool = (pidx < 20'(TABLE_COUNT));
    pool_t  = pidx[TW-1:0];
    di      = it_r.lin_addr[31:22];
    ti      = it_r.lin_addr[21:12];
  end

  logic [31:0] pte_val;
  logic        was_p, now_p;
  assign pte_val = (it_r.phys_addr & tlpt_pkg::FRAME_MASK) | {20'd0, it_r.flags};
  assign was_p   = pool_rd[0];
  assign now_p   = it_r.flags[0];

  assign q_pop      = (state_r == tlpt_pkg::ST_IDLE) && q_valid;
  assign res_valid  = (state_r == tlpt_pkg::ST_DONE);
  assign res_phys   = phys_r;
  assign res_mapped = map_r;
  assign res_status = stat_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    tsel_nxt  = tsel_r;
    phys_nxt  = phys_r;
    map_nxt   = map_r;
    stat_nxt  = stat_r;
    dir_we    = 1'b0;
    pool_we   = 1'b0;
    dir_addr  = di;
    pool_addr = PW'({tsel_r, ti});
    dir_wd    = '0;
    pool_wd   = pte_val;
    case (state_r)
      tlpt_pkg::ST_CLEAR: begin
        dir_we    = 1'b1;
        pool_we   = 1'b1;
        dir_addr  = clr_r[tlpt_pkg::IDX_W-1:0];
        pool_addr = clr_r[PW-1:0];
        pool_wd   = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == (CLRW+1)'((1 << CLRW) - 1)) begin
          state_nxt = tlpt_pkg::ST_IDLE;
        end
      end
      tlpt_pkg::ST_IDLE: begin
        // directory read for the item being popped
        dir_addr = q_item.lin_addr[31:22];
        if (q_valid) begin
          state_nxt = tlpt_pkg::ST_DIR;
        end
      end
      tlpt_pkg::ST_DIR: begin
        phys_nxt = '0;
        map_nxt  = 1'b0;
        stat_nxt = tlpt_pkg::STATUS_OK;
        state_nxt = tlpt_pkg::ST_DONE;
        case (it_r.kind)
          tlpt_pkg::KIND_MAP_LARGE: begin
            dir_we = 1'b1;
            dir_wd = (it_r.phys_addr & tlpt_pkg::LARGE_MASK) | tlpt_pkg::SIZE_BIT
                     | {20'd0, it_r.flags};
          end
          tlpt_pkg::KIND_MAP_SMALL: begin
            if (!dir_rd[0]) begin
              if (!free_found) begin
                stat_nxt = tlpt_pkg::STATUS_NO_TABLE;
              end else begin
                dir_we    = 1'b1;
                dir_wd    = {pool_frame + 20'(free_idx), 12'd0} | tlpt_pkg::LINK_FLAGS;
                tsel_nxt  = free_idx;
                state_nxt = tlpt_pkg::ST_TBL;
              end
            end else if (dir_rd[7]) begin
              stat_nxt = tlpt_pkg::STATUS_OVER_BIG;
            end else if (!in_pool) begin
              stat_nxt = tlpt_pkg::STATUS_NO_TABLE;
            end else begin
              tsel_nxt  = pool_t;
              state_nxt = tlpt_pkg::ST_TBL;
            end
          end
          tlpt_pkg::KIND_TRANSLATE: begin
            if (dir_rd[0]) begin
              if (dir_rd[7]) begin
                phys_nxt = (dir_rd & tlpt_pkg::LARGE_MASK)
                           | (it_r.lin_addr & tlpt_pkg::LARGE_OFF);
                map_nxt  = 1'b1;
              end else if (in_pool) begin
                tsel_nxt  = pool_t;
                state_nxt = tlpt_pkg::ST_TBL;
              end
            end
          end
          default: begin
          end
        endcase
      end
      tlpt_pkg::ST_TBL: begin
        // table read issued at pool_addr this cycle
        state_nxt = tlpt_pkg::ST_WRITE;
      end
      tlpt_pkg::ST_WRITE: begin
        state_nxt = tlpt_pkg::ST_DONE;
        if (it_r.kind == tlpt_pkg::KIND_MAP_SMALL) begin
          pool_we = 1'b1;
        end else if (pool_rd[0]) begin
          phys_nxt = (pool_rd & tlpt_pkg::FRAME_MASK)
                     | (it_r.lin_addr & tlpt_pkg::SMALL_OFF);
          map_nxt  = 1'b1;
        end
      end
      tlpt_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = tlpt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlpt_pkg::ST_CLEAR;
      clr_r   <= '0;
      for (int i = 0; i < TABLE_COUNT; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      // Present-entry counts follow table writes
      if (pool_we && state_r == tlpt_pkg::ST_WRITE) begin
        if (was_p && !now_p && cnt_r[tsel_r] != '0) begin
          cnt_r[tsel_r] <= cnt_r[tsel_r] - 1'b1;
        end else if (!was_p && now_p
                     && cnt_r[tsel_r] < tlpt_pkg::CNT_W'(tlpt_pkg::DIR_SIZE)) begin
          cnt_r[tsel_r] <= cnt_r[tsel_r] + 1'b1;
        end
      end
    end
    if (q_pop) begin
      it_r <= q_item;
    end
    tsel_r <= tsel_nxt;
    phys_r <= phys_nxt;
    map_r  <= map_nxt;
    stat_r <= stat_nxt;
  end
endmodule
`default_nettype wire

### hdl/two_level_page_table_map_and_walk.sv
// Top level of the two-level page table map and walk block.
// Usage:
//  - in_ channel carries one transaction per item: in_tuser = kind,
//    in_tdata = {flags, phys_addr, lin_addr}, with lin_addr in the low bits.
//  - out_ channel returns exactly one transaction per item:
//    out_tuser = status, out_tdata = {mapped, phys_result}.
//  - cfg_we/cfg_wdata set the pool frame; write only while idle.
// Timing:
//  - After reset the directory and pool RAMs are swept clear, one entry a
//    cycle; the queue takes up to two items meanwhile, and the back end
//    starts after the sweep.
//  - An item passes IDLE (directory read), DIR and DONE in the back end, or
//    IDLE, DIR, TBL, WRITE and DONE when it also reads or writes a table entry.
//  - The two-entry queue keeps accepting until full while a result waits; a stalled
//    out_tready holds the result and the back end.
`default_nettype none
module two_level_page_table_map_and_walk #(
  parameter int TABLE_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // lin_addr, phys_addr, flags, pad
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // phys_result, mapped, pad
  output logic [1:0]       out_tuser,  // status
  input  wire logic        cfg_we,
  input  wire logic [19:0] cfg_wdata
);
  logic [19:0]     pool_frame_r;
  tlpt_pkg::item_t in_item, q_item;
  logic            q_valid, q_pop, res_mapped;
  logic [31:0]     res_phys;
  logic [3:0]      unused_pad;

  always_ff @(posedge clk) begin
    if (!rst_n) pool_frame_r <= '0;
    else if (cfg_we) pool_frame_r <= cfg_wdata;
  end

  assign in_item.kind      = tlpt_pkg::kind_t'(in_tuser);
  assign in_item.lin_addr  = in_tdata[31:0];
  assign in_item.phys_addr = in_tdata[63:32];
  assign in_item.flags     = in_tdata[75:64];
  assign unused_pad        = in_tdata[79:76];

  tlpt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item));

  tlpt_back #(.TABLE_COUNT(TABLE_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .pool_frame(pool_frame_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_phys(res_phys),
    .res_mapped(res_mapped), .res_status(out_tuser));

  assign out_tdata = {7'd0, res_mapped, res_phys};
endmodule
`default_nettype wire
